@@ rtl/lru_key_value_cache_core_macros.svh @@
// Assertion macros for the LRU key-value cache core.
// Included by the modules that carry assertions; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while out of reset.
`define LKVC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lru cache assertion failed");

// Checked on every rising edge, reset included.
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lru cache assertion failed");

`else

`define LKVC_ASSERT(lbl, clk, rstn, prop)
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/lkvc_pkg.sv @@
// Shared constants and types of the LRU key-value cache core.
// No dependencies; used by lkvc_ctrl, lkvc_datapath and the top level.
package lkvc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int EFF_W     = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int DATA_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat
    logic lookup;  // register key match, LRU slot and free slot
    logic commit;  // update entries and load the result register
  } lkvc_cmd_t;

endpackage

@@ rtl/lru_key_value_cache_core.sv @@
// LRU key-value cache core: 16-entry fully associative store, LRU replacement.
// Each input beat passes a key compare step, then an update step, before its result beat.
// Input is refused during the key compare step; a new item is taken in the update step of the last one.
// A result waiting on out_ready_i stalls the update step of the next item.
// Reset (rst_ni low, async): entries invalid, occupancy 0, capacity 16.
module lru_key_value_cache_core
  import lkvc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic        [CAP_W-1:0]  cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic signed [DATA_W-1:0] write_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     hit_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic                     evicted_o,
  output logic signed [DATA_W-1:0] evicted_key_o
);

  lkvc_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lkvc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .write_value_i (write_value_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

endmodule

@@ rtl/lkvc_ctrl.sv @@
// Sequencing controller of the LRU key-value cache core.
// Depends on lkvc_pkg and lru_key_value_cache_core_macros.svh.
`include "lru_key_value_cache_core_macros.svh"

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lkvc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // result register can take a new beat
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_LOOKUP: in_ready_o = 1'b0;
      ST_UPDATE: in_ready_o = out_free;
      default:   in_ready_o = 1'b0;
    endcase
  end

  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.lookup = (state_q == ST_LOOKUP);
  assign cmd_o.commit = (state_q == ST_UPDATE) && out_free;
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) state_q <= in_valid_i ? ST_LOOKUP : ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `LKVC_ASSERT(a_load_then_lookup, clk_i, rst_ni, cmd_o.load |=> state_q == ST_LOOKUP)
  `LKVC_ASSERT(a_commit_sets_valid, clk_i, rst_ni, cmd_o.commit |=> out_valid_q)
  `LKVC_ASSERT(a_stall_holds_update, clk_i, rst_ni,
    (state_q == ST_UPDATE && out_valid_q && !out_ready_i) |=> state_q == ST_UPDATE)
  `LKVC_ASSERT(a_no_accept_in_lookup, clk_i, rst_ni,
    !(state_q == ST_LOOKUP && in_ready_o))

endmodule

@@ rtl/lkvc_datapath.sv @@
// Entry storage, key match, LRU selection and result register of the cache.
// Depends on lkvc_pkg and lru_key_value_cache_core_macros.svh.
`include "lru_key_value_cache_core_macros.svh"

module lkvc_datapath
  import lkvc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lkvc_cmd_t                cmd_i,
  input  logic                     cfg_we_i,
  input  logic        [CAP_W-1:0]  cfg_wdata_i,
  input  logic                     opcode_i,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic signed [DATA_W-1:0] write_value_i,
  output logic                     hit_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic                     evicted_o,
  output logic signed [DATA_W-1:0] evicted_key_o
);

  // configuration and occupancy
  logic [CAP_W-1:0] cap_q;
  logic [OCC_W-1:0] occ_q;
  logic [ENTRIES-1:0] valid_q;

  // entry storage
  logic [DATA_W-1:0] entry_key_q [ENTRIES];
  logic [DATA_W-1:0] entry_val_q [ENTRIES];
  logic [IDX_W-1:0]  rank_q      [ENTRIES];

  // captured input beat
  logic              op_q;
  logic [DATA_W-1:0] in_key_q;
  logic [DATA_W-1:0] in_val_q;

  // lookup results
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] lru_vec;
  logic [IDX_W-1:0]   hit_idx_d, lru_idx_d, free_idx_d;
  logic               free_any_d, full_d;
  logic [IDX_W-1:0]   hit_idx_q, lru_idx_q, free_idx_q;
  logic               hit_q, free_any_q, full_q;

  logic [EFF_W-1:0] cap_ext, eff_cap, occ_ext;
  logic [OCC_W-1:0] occ_m1;

  // commit controls
  logic              do_touch, do_insert, do_evict, put_hit;
  logic [IDX_W-1:0]  ins_slot;
  logic [IDX_W-1:0]  hit_rank;
  logic [DATA_W-1:0] hit_val, lru_key;

  // result register
  logic              res_hit_q, res_ev_q;
  logic [DATA_W-1:0] res_rval_q, res_evkey_q;

  assign cap_ext = EFF_W'(cap_q);
  assign occ_ext = EFF_W'(occ_q);
  assign occ_m1  = occ_q - OCC_W'(1);

  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = EFF_W'(1);
    end else if (cap_ext > EFF_W'(ENTRIES)) begin
      eff_cap = EFF_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // parallel key compare; the LRU entry holds rank occupancy-1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (entry_key_q[i] == in_key_q);
      lru_vec[i]   = valid_q[i] && (rank_q[i] == occ_m1[IDX_W-1:0]);
    end
  end

  always_comb begin
    hit_idx_d  = '0;
    lru_idx_d  = '0;
    free_idx_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx_d  = IDX_W'(i);
      if (lru_vec[i])   lru_idx_d  = IDX_W'(i);
      if (!valid_q[i])  free_idx_d = IDX_W'(i);
    end
    free_any_d = !(&valid_q);
    full_d     = (occ_ext >= eff_cap) && (occ_q != '0);
  end

  assign hit_rank = rank_q[hit_idx_q];
  assign hit_val  = entry_val_q[hit_idx_q];
  assign lru_key  = entry_key_q[lru_idx_q];

  assign do_touch  = cmd_i.commit && hit_q;
  assign put_hit   = do_touch && (op_q == OP_PUT);
  assign do_evict  = cmd_i.commit && (op_q == OP_PUT) && !hit_q && full_q;
  assign do_insert = cmd_i.commit && (op_q == OP_PUT) && !hit_q && (full_q || free_any_q);
  assign ins_slot  = full_q ? lru_idx_q : free_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      occ_q   <= '0;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (do_insert) begin
        valid_q[ins_slot] <= 1'b1;
        // an eviction frees and refills the same slot
        if (!do_evict) occ_q <= occ_q + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      in_key_q <= key_i;
      in_val_q <= write_value_i;
    end
    if (cmd_i.lookup) begin
      hit_q      <= |match_vec;
      hit_idx_q  <= hit_idx_d;
      lru_idx_q  <= lru_idx_d;
      free_idx_q <= free_idx_d;
      free_any_q <= free_any_d;
      full_q     <= full_d;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_touch) begin
        if (IDX_W'(i) == hit_idx_q) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_q[i] <= rank_q[i] + IDX_W'(1);
        end
      end else if (do_insert) begin
        if (IDX_W'(i) == ins_slot) begin
          rank_q[i] <= '0;
        end else if (valid_q[i]) begin
          rank_q[i] <= rank_q[i] + IDX_W'(1);
        end
      end
    end
    if (put_hit) entry_val_q[hit_idx_q] <= in_val_q;
    if (do_insert) begin
      entry_key_q[ins_slot] <= in_key_q;
      entry_val_q[ins_slot] <= in_val_q;
    end
    if (cmd_i.commit) begin
      res_hit_q   <= hit_q;
      res_ev_q    <= do_evict;
      res_evkey_q <= do_evict ? lru_key : '0;
      if (op_q == OP_PUT) begin
        res_rval_q <= '0;
      end else begin
        res_rval_q <= hit_q ? hit_val : '1;
      end
    end
  end

  assign hit_o         = res_hit_q;
  assign evicted_o     = res_ev_q;
  assign read_value_o  = res_rval_q;
  assign evicted_key_o = res_evkey_q;

  `LKVC_ASSERT(a_occ_bounded, clk_i, rst_ni, occ_q <= OCC_W'(ENTRIES))
  `LKVC_ASSERT(a_occ_matches_valid, clk_i, rst_ni, $countones(valid_q) == occ_q)
  `LKVC_ASSERT(a_keys_unique, clk_i, rst_ni, cmd_i.lookup |-> $onehot0(match_vec))

endmodule
